// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL of the segment allocator, included by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SFA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFA_ASSERT(lbl, clk, rstn, prop, msg)
`define SFA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/sfa_pkg.sv =====
// Package with the types and constants of the segment allocator.
package sfa_pkg;
    localparam int MAX_SEGMENTS = 1024;
    localparam int SIZE_W = 32;
    localparam int HANDLE_W = 32;
    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    localparam logic [1:0] FIT_BEST = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic CFG_FIT_POLICY = 1'b0;
    localparam logic CFG_POOL_SIZE = 1'b1;

    localparam logic OP_ALLOC = 1'b0;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_BAD_SIZE = 3'd1,
        ST_NO_FIT = 3'd2,
        ST_FULL = 3'd3,
        ST_UNKNOWN = 3'd4
    } status_t;

    typedef struct packed {
        logic [SIZE_W-1:0]   offset;
        logic [SIZE_W-1:0]   length;
        logic                is_free;
        logic [HANDLE_W-1:0] handle;
    } seg_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_DECIDE,
        S_UP_RD,
        S_UP_WR,
        S_SPLIT_WR,
        S_GRANT_WR,
        S_NXT_RD,
        S_NXT_EV,
        S_MERGE_WR,
        S_DN_RD,
        S_DN_WR,
        S_FIN
    } state_t;
endpackage

// ===== hw/rtl/sfa_seg_ram.sv =====
// Segment table memory with one write port and one registered read port.
module sfa_seg_ram
    import sfa_pkg::*;
(
    input  logic             aclk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  seg_entry_t       wdata,
    input  logic [IDX_W-1:0] raddr,
    output seg_entry_t       rdata
);
    seg_entry_t mem [MAX_SEGMENTS];
    seg_entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== hw/rtl/segment_fit_allocator.sv =====
// Top level of the segment allocator: request sequencer around the segment table.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tuser operation, s_tdata size and handle
//  m_      | out | m_tvalid/m_tready  | m_tuser status, m_tdata handle and offset
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_wdata
//
// One request is worked at a time. The table scan reads and then evaluates each entry
// (S_SCAN_RD, S_SCAN_EV), and an insert or removal moves one entry at a time, with a
// read and a write state each, over the single read and write ports of the table memory.
// After reset the table holds one empty free segment; no clearing pass is needed.
// A stalled result waits in the output register.
`include "assert_macros.svh"
module segment_fit_allocator
    import sfa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // request_size [31:0], request_handle [63:32]
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // granted_handle [31:0], granted_offset [63:32]
    output logic [2:0]  m_tuser,   // status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);
    state_t              state_reg, state_next;
    logic [1:0]          policy_reg, policy_next;
    logic [SIZE_W-1:0]   pool_reg, pool_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [HANDLE_W-1:0] hcnt_reg, hcnt_next;
    logic                fresh_reg, fresh_next;
    logic                op_reg, op_next;
    logic [SIZE_W-1:0]   want_reg, want_next;
    logic [HANDLE_W-1:0] hreq_reg, hreq_next;
    logic [CNT_W-1:0]    i_reg, i_next;
    logic                found_reg, found_next;
    logic [IDX_W-1:0]    best_reg, best_next;
    seg_entry_t          best_e_reg, best_e_next;
    seg_entry_t          prev_e_reg, prev_e_next;
    seg_entry_t          cur_e_reg, cur_e_next;
    logic [IDX_W-1:0]    cur_reg, cur_next;
    logic                nfree_reg, nfree_next;
    logic [SIZE_W-1:0]   nlen_reg, nlen_next;
    logic [CNT_W-1:0]    dst_reg, dst_next;
    logic [CNT_W-1:0]    src_reg, src_next;
    logic [1:0]          rcnt_reg, rcnt_next;
    status_t             rstat_reg, rstat_next;
    logic [HANDLE_W-1:0] rhandle_reg, rhandle_next;
    logic [SIZE_W-1:0]   roffset_reg, roffset_next;
    logic                ov_reg, ov_next;
    status_t             ostat_reg, ostat_next;
    logic [HANDLE_W-1:0] ohandle_reg, ohandle_next;
    logic [SIZE_W-1:0]   ooffset_reg, ooffset_next;

    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    seg_entry_t       wdata, rdata, ev;
    logic             fit, left;
    logic [IDX_W-1:0] tgt;
    logic [HANDLE_W-1:0] hinc;

    sfa_seg_ram u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid = ov_reg;
    assign m_tuser = ostat_reg;
    assign m_tdata = {ooffset_reg, ohandle_reg};

    always_comb begin
        state_next = state_reg;
        policy_next = policy_reg;
        pool_next = pool_reg;
        count_next = count_reg;
        hcnt_next = hcnt_reg;
        fresh_next = fresh_reg;
        op_next = op_reg;
        want_next = want_reg;
        hreq_next = hreq_reg;
        i_next = i_reg;
        found_next = found_reg;
        best_next = best_reg;
        best_e_next = best_e_reg;
        prev_e_next = prev_e_reg;
        cur_e_next = cur_e_reg;
        cur_next = cur_reg;
        nfree_next = nfree_reg;
        nlen_next = nlen_reg;
        dst_next = dst_reg;
        src_next = src_reg;
        rcnt_next = rcnt_reg;
        rstat_next = rstat_reg;
        rhandle_next = rhandle_reg;
        roffset_next = roffset_reg;
        ov_next = ov_reg && !m_tready;
        ostat_next = ostat_reg;
        ohandle_next = ohandle_reg;
        ooffset_next = ooffset_reg;
        we = 1'b0;
        waddr = '0;
        wdata = rdata;
        raddr = '0;
        hinc = hcnt_reg + 1'b1;

        if (i_reg == '0 && fresh_reg) begin
            ev = '{offset: '0, length: pool_reg, is_free: 1'b1, handle: '0};
        end else begin
            ev = rdata;
        end
        fit = ev.is_free && (ev.length >= want_reg);
        left = (cur_reg != '0) && prev_e_reg.is_free;
        tgt = left ? cur_reg - 1'b1 : cur_reg;

        if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_FIT_POLICY) begin
                policy_next = cfg_wdata[1:0];
            end else begin
                pool_next = cfg_wdata;
                count_next = CNT_W'(1);
                hcnt_next = HANDLE_W'(1);
                fresh_next = 1'b1;
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next = s_tuser;
                    want_next = s_tdata[31:0];
                    hreq_next = s_tdata[63:32];
                    i_next = '0;
                    found_next = 1'b0;
                    rhandle_next = '0;
                    roffset_next = '0;
                    if (s_tuser == OP_ALLOC && (pool_reg == '0 || s_tdata[31:0] == '0)) begin
                        rstat_next = ST_BAD_SIZE;
                        state_next = S_FIN;
                    end else begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                raddr = i_reg[IDX_W-1:0];
                if (i_reg == count_reg) begin
                    if (op_reg == OP_ALLOC) begin
                        state_next = S_DECIDE;
                    end else begin
                        rstat_next = ST_UNKNOWN;
                        state_next = S_FIN;
                    end
                end else begin
                    state_next = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                i_next = i_reg + 1'b1;
                state_next = S_SCAN_RD;
                if (op_reg == OP_ALLOC) begin
                    if (fit) begin
                        if (!found_reg) begin
                            found_next = 1'b1;
                            best_next = i_reg[IDX_W-1:0];
                            best_e_next = ev;
                            if (policy_reg != FIT_BEST && policy_reg != FIT_WORST) begin
                                state_next = S_DECIDE;
                            end
                        end else if ((policy_reg == FIT_BEST && ev.length < best_e_reg.length)
                                || (policy_reg == FIT_WORST && ev.length > best_e_reg.length)) begin
                            best_next = i_reg[IDX_W-1:0];
                            best_e_next = ev;
                        end
                    end
                end else if (!ev.is_free && ev.handle == hreq_reg) begin
                    cur_next = i_reg[IDX_W-1:0];
                    cur_e_next = ev;
                    nfree_next = 1'b0;
                    nlen_next = '0;
                    state_next = (i_reg + 1'b1 < count_reg) ? S_NXT_RD : S_MERGE_WR;
                end else begin
                    prev_e_next = ev;
                end
            end
            S_DECIDE: begin
                if (!found_reg) begin
                    rstat_next = ST_NO_FIT;
                    state_next = S_FIN;
                end else if (best_e_reg.length > want_reg) begin
                    if (count_reg >= CNT_W'(MAX_SEGMENTS)) begin
                        rstat_next = ST_FULL;
                        state_next = S_FIN;
                    end else begin
                        dst_next = count_reg;
                        state_next = S_UP_RD;
                    end
                end else begin
                    state_next = S_GRANT_WR;
                end
            end
            S_UP_RD: begin
                raddr = IDX_W'(dst_reg - 1'b1);
                if (dst_reg == {1'b0, best_reg} + 1'b1) begin
                    state_next = S_SPLIT_WR;
                end else begin
                    state_next = S_UP_WR;
                end
            end
            S_UP_WR: begin
                we = 1'b1;
                waddr = dst_reg[IDX_W-1:0];
                wdata = rdata;
                dst_next = dst_reg - 1'b1;
                state_next = S_UP_RD;
            end
            S_SPLIT_WR: begin
                we = 1'b1;
                waddr = best_reg + 1'b1;
                wdata = '{offset: best_e_reg.offset + want_reg,
                          length: best_e_reg.length - want_reg,
                          is_free: 1'b1, handle: '0};
                count_next = count_reg + 1'b1;
                state_next = S_GRANT_WR;
            end
            S_GRANT_WR: begin
                we = 1'b1;
                waddr = best_reg;
                wdata = '{offset: best_e_reg.offset, length: want_reg,
                          is_free: 1'b0, handle: hcnt_reg};
                rstat_next = ST_OK;
                rhandle_next = hcnt_reg;
                roffset_next = best_e_reg.offset;
                hcnt_next = (hinc == '0) ? HANDLE_W'(1) : hinc;
                state_next = S_FIN;
            end
            S_NXT_RD: begin
                raddr = cur_reg + 1'b1;
                state_next = S_NXT_EV;
            end
            S_NXT_EV: begin
                nfree_next = rdata.is_free;
                nlen_next = rdata.length;
                state_next = S_MERGE_WR;
            end
            S_MERGE_WR: begin
                we = 1'b1;
                waddr = tgt;
                wdata = '{offset: left ? prev_e_reg.offset : cur_e_reg.offset,
                          length: cur_e_reg.length + (nfree_reg ? nlen_reg : '0)
                                  + (left ? prev_e_reg.length : '0),
                          is_free: 1'b1, handle: '0};
                rcnt_next = {1'b0, left} + {1'b0, nfree_reg};
                dst_next = {1'b0, tgt} + 1'b1;
                src_next = {1'b0, tgt} + 1'b1 + {1'b0, left} + {1'b0, nfree_reg};
                rstat_next = ST_OK;
                state_next = (left || nfree_reg) ? S_DN_RD : S_FIN;
            end
            S_DN_RD: begin
                raddr = src_reg[IDX_W-1:0];
                if (src_reg >= count_reg) begin
                    count_next = count_reg - {{(CNT_W-2){1'b0}}, rcnt_reg};
                    state_next = S_FIN;
                end else begin
                    state_next = S_DN_WR;
                end
            end
            S_DN_WR: begin
                we = 1'b1;
                waddr = dst_reg[IDX_W-1:0];
                wdata = rdata;
                dst_next = dst_reg + 1'b1;
                src_next = src_reg + 1'b1;
                state_next = S_DN_RD;
            end
            S_FIN: begin
                if (!ov_reg || m_tready) begin
                    ov_next = 1'b1;
                    ostat_next = rstat_reg;
                    ohandle_next = rhandle_reg;
                    ooffset_next = roffset_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (we && waddr == '0) begin
            fresh_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            policy_reg <= '0;
            pool_reg <= '0;
            count_reg <= CNT_W'(1);
            hcnt_reg <= HANDLE_W'(1);
            fresh_reg <= 1'b1;
            ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            policy_reg <= policy_next;
            pool_reg <= pool_next;
            count_reg <= count_next;
            hcnt_reg <= hcnt_next;
            fresh_reg <= fresh_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg <= op_next;
        want_reg <= want_next;
        hreq_reg <= hreq_next;
        i_reg <= i_next;
        found_reg <= found_next;
        best_reg <= best_next;
        best_e_reg <= best_e_next;
        prev_e_reg <= prev_e_next;
        cur_e_reg <= cur_e_next;
        cur_reg <= cur_next;
        nfree_reg <= nfree_next;
        nlen_reg <= nlen_next;
        dst_reg <= dst_next;
        src_reg <= src_next;
        rcnt_reg <= rcnt_next;
        rstat_reg <= rstat_next;
        rhandle_reg <= rhandle_next;
        roffset_reg <= roffset_next;
        ostat_reg <= ostat_next;
        ohandle_reg <= ohandle_next;
        ooffset_reg <= ooffset_next;
    end

    `SFA_ASSERT(a_count_range, aclk, aresetn, (count_reg != '0) && (count_reg <= CNT_W'(MAX_SEGMENTS)), "segment count out of range")
    `SFA_ASSERT(a_handle_nonzero, aclk, aresetn, hcnt_reg != '0, "handle counter is zero")
    `SFA_ASSERT(a_no_idle_write, aclk, aresetn, we |-> (state_reg != S_IDLE), "table written while idle")
    `SFA_ASSERT(a_accept_starts, aclk, aresetn, (s_tvalid && s_tready) |=> (state_reg != S_IDLE), "accepted request not started")
endmodule
